// File: src/ufr_pkg.sv
// Shared types and codes for the rollback disjoint-set engine.
package ufr_pkg;

  localparam int NUM_ELEMENTS  = 1024;
  localparam int HISTORY_DEPTH = 2048;

  typedef enum logic [2:0] {
    FUNC_UNITE    = 3'd0,
    FUNC_QUERY    = 3'd1,
    FUNC_UNDO     = 3'd2,
    FUNC_SNAPSHOT = 3'd3,
    FUNC_ROLLBACK = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_HIGH  = 2'd3
  } err_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DISPATCH,
    ST_FIND_RD,
    ST_FIND_WT,
    ST_FIND_CHK,
    ST_UNITE_RD,
    ST_UNITE_WT,
    ST_UNITE_WR,
    ST_UNDO_RD,
    ST_UNDO_WT,
    ST_UNDO_WR1,
    ST_UNDO_WR0,
    ST_Q_RD,
    ST_Q_WT,
    ST_DONE
  } state_e;

endpackage

// File: src/union_find_with_rollback.sv
// Top level of the rollback disjoint-set engine (union by size, undo history).
//
// Usage: drive func_i, elem_a_i, elem_b_i, target_state_i and use_snapshot_i and
// pulse start_i while busy_o is low; the item is taken at that clock edge.
// busy_o stays high from that edge through the cycle in which done_o is high, so
// the next item can be taken at the end of the cycle after done_o. The result
// ports hold one result for exactly one cycle, marked by done_o; the receiver
// cannot stall.
// Element state lives in one single-port synchronous RAM of NUM_ELEMENTS
// entries, the undo history in a second RAM of HISTORY_DEPTH records.
// Every item ends with root walks of both elements, each of at most
// log2(NUM_ELEMENTS) parent hops; a unite also walks before writing, a unite
// that merges writes the demoted root's link in a further state, and an undo or
// rollback reads each undone record and restores its two element entries.
// After reset the element RAM is cleared to "own set of one" by a pass over all
// NUM_ELEMENTS entries, during which busy_o is high and no item is taken.
module union_find_with_rollback
  import ufr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  func_i,
  input  logic [9:0]  elem_a_i,
  input  logic [9:0]  elem_b_i,
  input  logic [11:0] target_state_i,
  input  logic        use_snapshot_i,
  output logic        done_o,
  output logic [9:0]  root_a_o,
  output logic [9:0]  root_b_o,
  output logic        same_set_o,
  output logic [10:0] set_size_o,
  output logic        merged_o,
  output logic [11:0] unite_count_o,
  output logic [1:0]  error_o
);

  localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int EW = AW + 2;
  localparam int RW = 2 * (AW + EW);
  localparam logic [AW-1:0] LastIdx = AW'(NUM_ELEMENTS - 1);

  // element RAM
  logic [EW-1:0] elem_mem [NUM_ELEMENTS];
  logic [EW-1:0] e_rdata_q;
  logic [AW-1:0] e_addr;
  logic          e_we;
  logic [EW-1:0] e_wdata;

  always_ff @(posedge clk_i) begin
    if (e_we) begin
      elem_mem[e_addr] <= e_wdata;
    end
    e_rdata_q <= elem_mem[e_addr];
  end

  // history RAM
  logic [RW-1:0] hist_mem [HISTORY_DEPTH];
  logic [RW-1:0] h_rdata_q;
  logic [HW-1:0] h_addr;
  logic          h_we;
  logic [RW-1:0] h_wdata;

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hist_mem[h_addr] <= h_wdata;
    end
    h_rdata_q <= hist_mem[h_addr];
  end

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [2:0]    func_q, func_d;
  logic [AW-1:0] a_q, a_d, b_q, b_d;
  logic [CW-1:0] goal_q, goal_d;
  logic [CW-1:0] cnt_q, cnt_d, snap_q, snap_d;
  logic [AW-1:0] walk_q, walk_d;
  logic          which_q, which_d;
  logic          post_q, post_d;
  logic [AW-1:0] ra_q, ra_d, rb_q, rb_d;
  logic [EW-1:0] va_q, va_d, vb_q, vb_d;
  logic          merged_q, merged_d;
  logic [1:0]    err_q, err_d;
  logic [AW-1:0] wr_idx_q, wr_idx_d;
  logic [EW-1:0] wr_val_q, wr_val_d;

  logic [AW-1:0] in_a, in_b;
  logic [AW-1:0] x_idx, y_idx;
  logic [EW-1:0] x_val, y_val, sum_val;
  logic [AW-1:0] h_idx0, h_idx1;
  logic [EW-1:0] h_val0, h_val1;
  logic [EW-1:0] neg_sz;

  assign in_a = ({2'b0, elem_a_i} >= 12'(NUM_ELEMENTS)) ? LastIdx : AW'(elem_a_i);
  assign in_b = ({2'b0, elem_b_i} >= 12'(NUM_ELEMENTS)) ? LastIdx : AW'(elem_b_i);

  assign {h_idx1, h_val1, h_idx0, h_val0} = h_rdata_q;

  // larger set (more negative) becomes the new root
  always_comb begin
    if ($signed(va_q) > $signed(vb_q)) begin
      x_idx = rb_q; x_val = vb_q; y_idx = ra_q; y_val = va_q;
    end else begin
      x_idx = ra_q; x_val = va_q; y_idx = rb_q; y_val = vb_q;
    end
  end
  assign sum_val = x_val + y_val;
  assign neg_sz  = -e_rdata_q;

  // goal from target_state: keep the target itself in a register as wide as target_state_i
  logic [11:0] tgt_q, tgt_d;
  logic        tgt_sel_q, tgt_sel_d;

  always_comb begin
    state_d = state_q; clr_d = clr_q; func_d = func_q; a_d = a_q; b_d = b_q;
    goal_d = goal_q; cnt_d = cnt_q; snap_d = snap_q; walk_d = walk_q;
    which_d = which_q; post_d = post_q; ra_d = ra_q; rb_d = rb_q; va_d = va_q;
    vb_d = vb_q; merged_d = merged_q; err_d = err_q; wr_idx_d = wr_idx_q;
    wr_val_d = wr_val_q; tgt_d = tgt_q; tgt_sel_d = tgt_sel_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LastIdx) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          func_d = func_i; a_d = in_a; b_d = in_b;
          tgt_d = target_state_i; tgt_sel_d = use_snapshot_i;
          merged_d = 1'b0; err_d = ERR_NONE;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        post_d = 1'b1; which_d = 1'b0; walk_d = a_q;
        state_d = ST_FIND_RD;
        unique case (func_q)
          FUNC_UNITE: begin
            if ({{(33-CW){1'b0}}, cnt_q} >= 33'(HISTORY_DEPTH)) err_d = ERR_FULL;
            else post_d = 1'b0;
          end
          FUNC_UNDO: begin
            if (cnt_q == '0) err_d = ERR_EMPTY;
            else begin
              goal_d = cnt_q - CW'(1); state_d = ST_UNDO_RD;
            end
          end
          FUNC_SNAPSHOT: snap_d = cnt_q;
          FUNC_ROLLBACK: begin
            if (tgt_sel_q) goal_d = snap_q;
            else if ({{(33-CW){1'b0}}, cnt_q} < {21'b0, tgt_q}) goal_d = cnt_q + CW'(1);
            else goal_d = CW'(tgt_q);
            if ((tgt_sel_q && snap_q > cnt_q) ||
                (!tgt_sel_q && {{(33-CW){1'b0}}, cnt_q} < {21'b0, tgt_q})) begin
              err_d = ERR_HIGH;
            end else if (goal_d != cnt_q) state_d = ST_UNDO_RD;
          end
          default: ;
        endcase
      end
      ST_FIND_RD: state_d = ST_FIND_WT;
      ST_FIND_WT: state_d = ST_FIND_CHK;
      ST_FIND_CHK: begin
        if (e_rdata_q[EW-1]) begin
          if (!which_q) begin
            ra_d = walk_q; va_d = e_rdata_q; which_d = 1'b1; walk_d = b_q;
            state_d = ST_FIND_RD;
          end else begin
            rb_d = walk_q; vb_d = e_rdata_q;
            state_d = post_q ? ST_Q_RD : ST_UNITE_WR;
          end
        end else begin
          walk_d = e_rdata_q[AW-1:0];
          state_d = ST_FIND_RD;
        end
      end
      ST_UNITE_WR: begin
        cnt_d = cnt_q + CW'(1);
        if (ra_q != rb_q) begin
          wr_idx_d = y_idx; wr_val_d = {{(EW-AW){1'b0}}, x_idx};
          merged_d = 1'b1; state_d = ST_UNITE_RD;
        end else begin
          post_d = 1'b1; which_d = 1'b0; walk_d = a_q; state_d = ST_FIND_RD;
        end
      end
      ST_UNITE_RD: begin
        post_d = 1'b1; which_d = 1'b0; walk_d = a_q; state_d = ST_FIND_RD;
      end
      ST_UNDO_RD: state_d = ST_UNDO_WT;
      ST_UNDO_WT: state_d = ST_UNDO_WR1;
      ST_UNDO_WR1: state_d = ST_UNDO_WR0;
      ST_UNDO_WR0: begin
        cnt_d = cnt_q - CW'(1);
        if (cnt_d == goal_q) begin
          post_d = 1'b1; which_d = 1'b0; walk_d = a_q; state_d = ST_FIND_RD;
        end else state_d = ST_UNDO_RD;
      end
      ST_Q_RD: state_d = ST_Q_WT;
      ST_Q_WT: state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    e_addr = walk_q; e_we = 1'b0; e_wdata = wr_val_q;
    h_addr = HW'(cnt_q - CW'(1)); h_we = 1'b0;
    h_wdata = {rb_q, vb_q, ra_q, va_q};
    unique case (state_q)
      ST_CLEAR: begin
        e_addr = clr_q; e_we = 1'b1; e_wdata = '1;
      end
      ST_UNITE_WR: begin
        h_addr = HW'(cnt_q); h_we = 1'b1;
        if (ra_q != rb_q) begin
          e_addr = x_idx; e_we = 1'b1; e_wdata = sum_val;
        end
      end
      ST_UNITE_RD: begin
        e_addr = wr_idx_q; e_we = 1'b1; e_wdata = wr_val_q;
      end
      ST_UNDO_WR1: begin
        e_addr = h_idx1; e_we = 1'b1; e_wdata = h_val1;
      end
      ST_UNDO_WR0: begin
        e_addr = h_idx0; e_we = 1'b1; e_wdata = h_val0;
      end
      ST_Q_RD, ST_Q_WT: e_addr = ra_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      snap_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      snap_q  <= snap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; a_q <= a_d; b_q <= b_d; goal_q <= goal_d;
    walk_q <= walk_d; which_q <= which_d; post_q <= post_d;
    ra_q <= ra_d; rb_q <= rb_d; va_q <= va_d; vb_q <= vb_d;
    merged_q <= merged_d; err_q <= err_d; wr_idx_q <= wr_idx_d;
    wr_val_q <= wr_val_d; tgt_q <= tgt_d; tgt_sel_q <= tgt_sel_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = (state_q == ST_DONE);
  assign root_a_o      = 10'(ra_q);
  assign root_b_o      = 10'(rb_q);
  assign same_set_o    = (ra_q == rb_q);
  assign set_size_o    = 11'(neg_sz);
  assign merged_o      = merged_q;
  assign unite_count_o = 12'(cnt_q);
  assign error_o       = err_q;

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the rollback disjoint-set engine.
module tb_top
  import ufr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NELEM = 1024;
  localparam int HDEPTH = 2048;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [2:0]  func;
    logic [9:0]  elem_a;
    logic [9:0]  elem_b;
    logic [11:0] target;
    logic        use_snap;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  root_a;
    logic [9:0]  root_b;
    logic        same_set;
    logic [10:0] set_size;
    logic        merged;
    logic [11:0] unite_count;
    logic [1:0]  error;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] func = '0;
  logic [9:0] elem_a = '0, elem_b = '0;
  logic [11:0] target = '0;
  logic use_snap = 1'b0;
  logic done;
  logic [9:0] root_a, root_b;
  logic same_set, merged;
  logic [10:0] set_size;
  logic [11:0] unite_count;
  logic [1:0] error;

  cmd_t pending_cmds[$];
  answer_t expected_answers[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;
  int gap = 0;

  int forest[NELEM];
  int hist_idx0[HDEPTH], hist_idx1[HDEPTH];
  int hist_val0[HDEPTH], hist_val1[HDEPTH];
  int hist_cnt = 0;
  int snap_cnt = 0;

  always #5 clk = ~clk;

  union_find_with_rollback DUT (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .func_i(func), .elem_a_i(elem_a), .elem_b_i(elem_b),
    .target_state_i(target), .use_snapshot_i(use_snap),
    .done_o(done), .root_a_o(root_a), .root_b_o(root_b), .same_set_o(same_set),
    .set_size_o(set_size), .merged_o(merged), .unite_count_o(unite_count),
    .error_o(error)
  );

  function automatic int root_of(int k);
    int r;
    r = k;
    while (forest[r] >= 0) r = forest[r];
    return r;
  endfunction

  function automatic void pop_record();
    hist_cnt--;
    forest[hist_idx1[hist_cnt]] = hist_val1[hist_cnt];
    forest[hist_idx0[hist_cnt]] = hist_val0[hist_cnt];
  endfunction

  function automatic answer_t apply_cmd(cmd_t c);
    answer_t ans;
    int a, b, x, y, t, goal;
    ans = '0;
    a = c.elem_a;
    b = c.elem_b;
    case (c.func)
      FUNC_UNITE: begin
        if (hist_cnt >= HDEPTH) begin
          ans.error = ERR_FULL;
        end else begin
          x = root_of(a);
          y = root_of(b);
          hist_idx0[hist_cnt] = x;
          hist_val0[hist_cnt] = forest[x];
          hist_idx1[hist_cnt] = y;
          hist_val1[hist_cnt] = forest[y];
          hist_cnt++;
          if (x != y) begin
            if (forest[x] > forest[y]) begin
              t = x; x = y; y = t;
            end
            forest[x] += forest[y];
            forest[y] = x;
            ans.merged = 1'b1;
          end
        end
      end
      FUNC_UNDO: begin
        if (hist_cnt == 0) ans.error = ERR_EMPTY;
        else pop_record();
      end
      FUNC_SNAPSHOT: snap_cnt = hist_cnt;
      FUNC_ROLLBACK: begin
        goal = c.use_snap ? snap_cnt : int'(c.target);
        if (goal > hist_cnt) ans.error = ERR_HIGH;
        else while (hist_cnt > goal) pop_record();
      end
      default: ;
    endcase
    x = root_of(a);
    y = root_of(b);
    ans.root_a = 10'(x);
    ans.root_b = 10'(y);
    ans.same_set = (x == y);
    ans.set_size = 11'(-forest[x]);
    ans.unite_count = 12'(hist_cnt);
    return ans;
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] f, int a, int b, int tg, bit s);
    cmd_t c;
    c.func = f;
    c.elem_a = 10'(a);
    c.elem_b = 10'(b);
    c.target = 12'(tg);
    c.use_snap = s;
    return c;
  endfunction

  function automatic cmd_t rand_cmd(int span);
    cmd_t c;
    int r;
    c.elem_a = 10'($urandom_range(span - 1));
    c.elem_b = 10'($urandom_range(span - 1));
    if ($urandom_range(19) == 0) c.elem_a = 10'($urandom);
    if ($urandom_range(19) == 0) c.elem_b = 10'($urandom);
    c.target = 12'($urandom_range(hist_cnt + 3));
    if ($urandom_range(29) == 0) c.target = 12'($urandom);
    c.use_snap = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < 50) c.func = FUNC_UNITE;
    else if (r < 70) c.func = FUNC_QUERY;
    else if (r < 82) c.func = FUNC_UNDO;
    else if (r < 89) c.func = FUNC_SNAPSHOT;
    else if (r < 97) c.func = FUNC_ROLLBACK;
    else c.func = 3'($urandom_range(7, 5));
    return c;
  endfunction

  // driver
  logic taken_flag = 1'b0;
  always @(posedge clk) begin
    taken_flag <= start && !busy && rst_n;
    if (start && !busy && rst_n)
      expected_answers.push_back(apply_cmd({func, elem_a, elem_b, target, use_snap}));
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !taken_flag) begin
      end else begin
        if (gap > 0) begin
          gap <= gap - 1;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0 && !quiet && $urandom_range(9) == 0) begin
          gap <= $urandom_range(14, 0);
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          {func, elem_a, elem_b, target, use_snap} <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
          func <= 3'($urandom);
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t got, want;
    cycle_count <= cycle_count + 1;
    if (done && rst_n) begin
      got = {root_a, root_b, same_set, set_size, merged, unite_count, error};
      if (expected_answers.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        want = expected_answers.pop_front();
        if (got.root_a !== want.root_a)
          $error("root_a exp %0d got %0d", want.root_a, got.root_a);
        if (got.root_b !== want.root_b)
          $error("root_b exp %0d got %0d", want.root_b, got.root_b);
        if (got.same_set !== want.same_set)
          $error("same_set exp %0d got %0d", want.same_set, got.same_set);
        if (got.set_size !== want.set_size)
          $error("set_size exp %0d got %0d", want.set_size, got.set_size);
        if (got.merged !== want.merged)
          $error("merged exp %0d got %0d", want.merged, got.merged);
        if (got.unite_count !== want.unite_count)
          $error("unite_count exp %0d got %0d", want.unite_count, got.unite_count);
        if (got.error !== want.error)
          $error("error exp %0d got %0d", want.error, got.error);
        if (got !== want) fail_count++;
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int n, span;
    for (int i = 0; i < NELEM; i++) forest[i] = -1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // directed: extremes, every func, error cases
    pending_cmds.push_back(make_cmd(FUNC_UNDO, 0, 1023, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_ROLLBACK, 0, 0, 1, 0));
    pending_cmds.push_back(make_cmd(FUNC_ROLLBACK, 1023, 0, 4095, 0));
    pending_cmds.push_back(make_cmd(FUNC_QUERY, 1023, 1023, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_UNITE, 0, 1023, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_UNITE, 1023, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_SNAPSHOT, 5, 6, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_UNITE, 1, 2, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_UNITE, 2, 1023, 0, 1));
    pending_cmds.push_back(make_cmd(FUNC_QUERY, 1, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_ROLLBACK, 1, 0, 0, 1));
    pending_cmds.push_back(make_cmd(FUNC_QUERY, 1, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_UNDO, 0, 1023, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_ROLLBACK, 0, 0, 0, 1));
    pending_cmds.push_back(make_cmd(3'd5, 682, 341, 2730, 1));
    pending_cmds.push_back(make_cmd(3'd7, 1023, 0, 1365, 0));
    pending_cmds.push_back(make_cmd(FUNC_ROLLBACK, 3, 4, 0, 0));
    // random: small element span keeps sets growing and paths long
    n = 0;
    while (n < 890) begin
      span = ($urandom_range(3) == 0) ? NELEM : 32;
      pending_cmds.push_back(rand_cmd(span));
      n++;
    end
    pending_cmds.push_back(make_cmd(FUNC_ROLLBACK, 0, 0, 0, 0));
    for (int i = 0; i < 40; i++) pending_cmds.push_back(rand_cmd(32));
    wait (pending_cmds.size() < 60);
    quiet = 1'b1;
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_answers.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
